### sv/kvs_pkg.sv
package kvs_pkg;

  localparam int SLOTS_DEF = 32;
  localparam int MAX_VALUE_BYTES_DEF = 128;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_BUFS   = 2'd2;

  typedef enum logic [2:0] {
    OP_STAGE   = 3'd0,
    OP_GET     = 3'd1,
    OP_SET     = 3'd2,
    OP_ADD     = 3'd3,
    OP_DEL_NTH = 3'd4,
    OP_DEL_ALL = 3'd5,
    OP_WIPE    = 3'd6,
    OP_NOP     = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] key;
    logic [4:0]  match_index;
    logic [7:0]  value_length;
    logic [7:0]  capacity;
    logic [3:0]  word_position;
    logic [63:0] value_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  stored_length;
    logic        is_data;
    logic [3:0]  data_position;
    logic [63:0] data_word;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_COPY_RD,
    S_COPY_WR,
    S_HDR,
    S_GET_RD,
    S_GET_WAIT,
    S_GET_OUT,
    S_RESP
  } state_t;

  // scan unit control
  typedef struct packed {
    logic start;
    logic match_key;
    logic want_free;
    logic invalidate_all;
  } scan_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found_hit;
    logic found_free;
    logic any_hit;
  } scan_sts_t;

endpackage

### sv/kvs_ram.sv
module kvs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

### sv/kvs_scan.sv
// Walks the slots one per cycle: one key compare, shared by all ops.
module kvs_scan #(
  parameter int SLOTS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  kvs_pkg::scan_ctl_t       ctl,
  input  logic [15:0]              key,
  input  logic [4:0]               nth,
  input  logic                     wipe,
  input  logic                     clr_en,
  input  logic [$clog2(SLOTS)-1:0] clr_idx,
  input  logic                     set_en,
  input  logic [$clog2(SLOTS)-1:0] set_idx,
  input  logic [15:0]              set_key,
  output kvs_pkg::scan_sts_t       sts,
  output logic [$clog2(SLOTS)-1:0] hit_idx,
  output logic [$clog2(SLOTS)-1:0] free_idx
);
  import kvs_pkg::*;
  localparam int IW = $clog2(SLOTS);

  logic [SLOTS-1:0] valid_r;
  logic [15:0]      key_r [SLOTS];
  logic             busy_r, done_r, fh_r, ff_r, any_r;
  logic [IW-1:0]    idx_r, hit_r, free_r;
  logic [4:0]       cnt_r;
  scan_ctl_t        c_r;
  logic             match;

  assign match = valid_r[idx_r] && key_r[idx_r] == key;

  // a slot freed by invalidate in the same pass counts as free
  always_ff @(posedge clk) begin
    if (set_en) key_r[set_idx] <= set_key;
    if (busy_r && match && !fh_r && cnt_r == nth) hit_r <= idx_r;
    if (busy_r && !ff_r && (!valid_r[idx_r] || (match && c_r.invalidate_all)))
      free_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      fh_r <= 1'b0;
      ff_r <= 1'b0;
      any_r <= 1'b0;
      idx_r <= '0;
      cnt_r <= '0;
      c_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        c_r <= ctl;
        idx_r <= '0;
        cnt_r <= '0;
        fh_r <= 1'b0;
        ff_r <= 1'b0;
        any_r <= 1'b0;
      end else if (busy_r) begin
        if (match) begin
          any_r <= 1'b1;
          if (cnt_r == nth) fh_r <= 1'b1;
          cnt_r <= cnt_r + 5'd1;
          if (c_r.invalidate_all) valid_r[idx_r] <= 1'b0;
        end
        if (!valid_r[idx_r] || (match && c_r.invalidate_all)) ff_r <= 1'b1;
        if (idx_r == IW'(SLOTS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (clr_en) valid_r[clr_idx] <= 1'b0;
      if (set_en) valid_r[set_idx] <= 1'b1;
      if (wipe) valid_r <= '0;
    end
  end

  assign sts = '{busy: busy_r, done: done_r, found_hit: fh_r, found_free: ff_r,
                 any_hit: any_r};
  assign hit_idx = hit_r;
  assign free_idx = free_r;
endmodule

### sv/keyed_multivalue_store.sv
// Keyed multi-value store: SLOTS slots, each a 16-bit key, a length and up
// to MAX_VALUE_BYTES bytes held as 64-bit words.
// Input channel in_valid/in_stall/in_data carries one op per beat; output
// channel out_valid/out_stall/out_data returns one beat per op, or a header
// plus up to MAX_VALUE_BYTES/8 data beats for a found get (last marks the
// final beat).
// Sequencing: stage word, wipe and no-op go straight to the response beat.
// Get, delete, set and add run one pass of the slot scanner, one slot per
// cycle. Add and set then copy the staging buffer into the slot, each word
// read (S_COPY_RD) and then written (S_COPY_WR); a found get streams its data
// words, each through S_GET_RD, S_GET_WAIT and S_GET_OUT. in_stall is high
// while an op runs.
// Reset: a synchronous active-low rst_n clears all valid bits; slot data
// is undefined until written. While out_stall is high a pending output beat
// holds and the sequencer waits before giving the next beat.
module keyed_multivalue_store #(
  parameter int SLOTS = kvs_pkg::SLOTS_DEF,
  parameter int MAX_VALUE_BYTES = kvs_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kvs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kvs_pkg::out_item_t out_data
);
  import kvs_pkg::*;
  localparam int WORDS = (MAX_VALUE_BYTES + 7) / 8;
  localparam int WB = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW = $clog2(SLOTS);
  localparam int SW = $clog2(SLOTS * WORDS);
  localparam int LW = $clog2(MAX_VALUE_BYTES + 1);

  state_t    state_r, state_nxt;
  in_item_t  req_r;
  logic [1:0] status_r, status_nxt;
  logic [WB-1:0] w_r, w_nxt;
  logic [WB:0]   nw_r, nw_nxt;
  logic [LW-1:0] copy_r, copy_nxt, len_r, len_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic       ov_r, ov_nxt;
  out_item_t  od_r, od_nxt;

  scan_ctl_t ctl;
  scan_sts_t sts;
  logic [IW-1:0] hit_idx, free_idx;
  logic wipe, clr_en, set_en;

  logic [LW-1:0] lens [SLOTS];
  logic [63:0] stg_rd, slot_rd;
  logic        stg_we, slot_we;
  logic [WB-1:0] stg_ra;
  logic [SW-1:0] slot_addr_w, slot_addr_r;
  logic [LW-1:0] rem;
  logic [63:0] mask;

  logic in_fire;
  assign in_fire = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign out_valid = ov_r;
  assign out_data = od_r;

  kvs_scan #(.SLOTS(SLOTS)) u_scan (
    .clk, .rst_n, .ctl, .key(req_r.key), .nth(req_r.match_index), .wipe,
    .clr_en, .clr_idx(hit_idx), .set_en, .set_idx(slot_r), .set_key(req_r.key),
    .sts, .hit_idx, .free_idx
  );

  kvs_ram #(.WIDTH(64), .DEPTH(WORDS)) u_stage (
    .clk, .wr_en(stg_we), .wr_addr(in_data.word_position[WB-1:0]),
    .wr_data(in_data.value_word), .rd_addr(stg_ra), .rd_data(stg_rd)
  );

  kvs_ram #(.WIDTH(64), .DEPTH(SLOTS * WORDS)) u_slots (
    .clk, .wr_en(slot_we), .wr_addr(slot_addr_w), .wr_data(stg_rd),
    .rd_addr(slot_addr_r), .rd_data(slot_rd)
  );

  assign stg_we = in_fire && in_data.op == OP_STAGE &&
                  {1'b0, in_data.word_position} < 5'(WORDS);
  assign stg_ra = w_r;
  assign slot_addr_w = SW'(slot_r * WORDS) + SW'(w_r);
  assign slot_addr_r = slot_addr_w;

  always_ff @(posedge clk) begin
    if (set_en) lens[slot_r] <= LW'(req_r.value_length);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_data;
    status_r <= status_nxt;
    w_r <= w_nxt;
    nw_r <= nw_nxt;
    copy_r <= copy_nxt;
    len_r <= len_nxt;
    slot_r <= slot_nxt;
    od_r <= od_nxt;
  end

  assign rem = copy_r - LW'({w_r, 3'b000});
  assign mask = (rem >= LW'(8)) ? '1 : ((64'd1 << {rem[2:0], 3'b000}) - 64'd1);

  always_comb begin
    state_nxt = state_r;
    status_nxt = status_r;
    w_nxt = w_r;
    nw_nxt = nw_r;
    copy_nxt = copy_r;
    len_nxt = len_r;
    slot_nxt = slot_r;
    ov_nxt = ov_r && out_stall;
    od_nxt = od_r;
    ctl = '0;
    wipe = 1'b0;
    clr_en = 1'b0;
    set_en = 1'b0;
    slot_we = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          status_nxt = ST_OK;
          w_nxt = '0;
          case (op_t'(in_data.op))
            OP_GET, OP_DEL_NTH, OP_DEL_ALL, OP_ADD, OP_SET: begin
              ctl.start = 1'b1;
              ctl.invalidate_all = in_data.op == OP_SET || in_data.op == OP_DEL_ALL;
              state_nxt = S_SCAN;
            end
            OP_WIPE: begin
              wipe = 1'b1;
              state_nxt = S_RESP;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.done) begin
          slot_nxt = free_idx;
          case (op_t'(req_r.op))
            OP_GET: begin
              if (sts.found_hit) begin
                slot_nxt = hit_idx;
                len_nxt = lens[hit_idx];
                state_nxt = S_HDR;
              end else begin
                status_nxt = ST_NOT_FOUND;
                state_nxt = S_RESP;
              end
            end
            OP_DEL_NTH: begin
              if (sts.found_hit) clr_en = 1'b1;
              else status_nxt = ST_NOT_FOUND;
              state_nxt = S_RESP;
            end
            OP_DEL_ALL: begin
              if (!sts.any_hit) status_nxt = ST_NOT_FOUND;
              state_nxt = S_RESP;
            end
            default: begin
              if (req_r.value_length > 8'(MAX_VALUE_BYTES) || !sts.found_free) begin
                status_nxt = ST_NO_BUFS;
                state_nxt = S_RESP;
              end else begin
                nw_nxt = (WB + 1)'(WORDS);
                state_nxt = S_COPY_RD;
              end
            end
          endcase
        end
      end
      S_COPY_RD: state_nxt = S_COPY_WR;
      S_COPY_WR: begin
        slot_we = 1'b1;
        if ({1'b0, w_r} == nw_r - 1'b1) begin
          set_en = 1'b1;
          state_nxt = S_RESP;
        end else begin
          w_nxt = w_r + 1'b1;
          state_nxt = S_COPY_RD;
        end
      end
      S_HDR: begin
        if (!ov_r || !out_stall) begin
          copy_nxt = (LW'(req_r.capacity) < len_r && req_r.capacity <= 8'(MAX_VALUE_BYTES))
                     ? LW'(req_r.capacity) : len_r;
          nw_nxt = (WB + 1)'((copy_nxt + LW'(7)) >> 3);
          ov_nxt = 1'b1;
          od_nxt = '0;
          od_nxt.stored_length = 8'(len_r);
          od_nxt.last = nw_nxt == '0;
          state_nxt = (nw_nxt == '0) ? S_IDLE : S_GET_RD;
        end
      end
      S_GET_RD: state_nxt = S_GET_WAIT;
      S_GET_WAIT: state_nxt = S_GET_OUT;
      S_GET_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          od_nxt.stored_length = 8'(len_r);
          od_nxt.is_data = 1'b1;
          od_nxt.data_position = 4'(w_r);
          od_nxt.data_word = slot_rd & mask;
          od_nxt.last = {1'b0, w_r} == nw_r - 1'b1;
          if (od_nxt.last) begin
            state_nxt = S_IDLE;
          end else begin
            w_nxt = w_r + 1'b1;
            state_nxt = S_GET_RD;
          end
        end
      end
      S_RESP: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          od_nxt.status = status_r;
          od_nxt.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### sv/kvs_checker.sv
module kvs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input kvs_pkg::out_item_t out_data
);
  import kvs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second item at once");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_data |-> out_data.status == ST_OK)
    else $error("data beat with error status");
endmodule

bind keyed_multivalue_store kvs_checker u_kvs_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
